// ----- src/ftp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Flow tuple header parser package
// Word types and protocol constants shared by the header parser.
// ----------------------------------------------------------------------------
package ftp_pkg;

    // One input word: a frame byte and its end-of-frame mark.
    typedef struct packed {
        logic [7:0] packet_byte;
        logic       last_byte;
    } t_ftp_in;

    // One result word, produced at the end of each frame.
    typedef struct packed {
        logic        parsed;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [7:0]  protocol;
        logic [15:0] sport;
        logic [15:0] dport;
    } t_ftp_out;

    localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_TCP  = 8'd6;
    localparam logic [7:0]  PROTO_UDP  = 8'd17;
    localparam logic [3:0]  IHL_MIN    = 4'd5;

    // Byte offsets inside the frame.
    localparam logic [6:0] POS_MAX       = 7'd127;
    localparam logic [6:0] POS_ETYPE_HI  = 7'd12;
    localparam logic [6:0] POS_ETYPE_LO  = 7'd13;
    localparam logic [6:0] POS_IHL       = 7'd14;
    localparam logic [6:0] POS_PROTO     = 7'd23;
    localparam logic [6:0] POS_SRC_FIRST = 7'd26;
    localparam logic [6:0] POS_SRC_LAST  = 7'd29;
    localparam logic [6:0] POS_DST_FIRST = 7'd30;
    localparam logic [6:0] POS_DST_LAST  = 7'd33;
    localparam logic [6:0] ETH_HDR_LEN   = 7'd14;

    // Minimum frame length and minimum transport header lengths.
    localparam logic [7:0] MIN_FRAME_LEN = 8'd34;
    localparam logic [7:0] TCP_HDR_LEN   = 8'd20;
    localparam logic [7:0] UDP_HDR_LEN   = 8'd8;

endpackage

`default_nettype wire

// ----- src/flow_tuple_header_parser.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Flow tuple header parser
// Extracts the IPv4 five-tuple from an Ethernet frame streamed a byte a word.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (i_valid, o_ready, i_data) carries one frame byte per
// word, in wire order, with last_byte set on the final byte. The output
// channel (o_valid, i_ready, o_data) carries one result word per frame.
// A frame is accepted at one word per clock cycle. The result word appears
// in the output register in the cycle after the final byte is accepted.
// Parsing state is captured directly as bytes arrive, so only compares and
// field captures sit between the input handshake and the result register.
// When the receiver stalls, a result stays in the output register and the
// input stalls with it until that result is taken; o_ready is low only
// while a result waits and i_ready is low.
// A synchronous active-low reset clears the byte counter, all captured
// header fields and the output valid flag.
// ----------------------------------------------------------------------------
module flow_tuple_header_parser (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_valid,
    output logic               o_ready,
    input  ftp_pkg::t_ftp_in   i_data,
    output logic               o_valid,
    input  wire                i_ready,
    output ftp_pkg::t_ftp_out  o_data
);
    import ftp_pkg::*;

    // Captured header state for the frame in progress.
    logic [6:0]  r_pos,      n_pos;
    logic [15:0] r_etype,    n_etype;
    logic [3:0]  r_ihl,      n_ihl;
    logic [7:0]  r_proto,    n_proto;
    logic [31:0] r_src_ip,   n_src_ip;
    logic [31:0] r_dst_ip,   n_dst_ip;
    logic [15:0] r_sport,    n_sport;
    logic [15:0] r_dport,    n_dport;

    // Result register.
    logic        r_out_valid, n_out_valid;
    t_ftp_out    r_out,       n_out;

    logic        in_fire;
    logic        out_fire;
    logic [7:0]  b;
    logic [6:0]  xport_ofs;
    logic [6:0]  xport_ofs_new;
    logic [7:0]  frame_len;
    logic        ok_base;
    logic        is_tcp;
    logic        is_udp;
    logic        ok;

    assign out_fire = r_out_valid && i_ready;
    // A word may enter whenever the result register is free or draining.
    assign o_ready  = !r_out_valid || i_ready;
    assign in_fire  = i_valid && o_ready;
    assign b        = i_data.packet_byte;

    // Transport offset from the header length held before this byte.
    assign xport_ofs = ETH_HDR_LEN + {1'b0, r_ihl, 2'b00};

    // Field capture: the header length and the port windows follow the
    // current byte position.
    always_comb begin
        n_etype    = r_etype;
        n_ihl      = r_ihl;
        n_proto    = r_proto;
        n_src_ip   = r_src_ip;
        n_dst_ip   = r_dst_ip;
        n_sport    = r_sport;
        n_dport    = r_dport;

        if (r_pos == POS_ETYPE_HI) begin
            n_etype = {b, r_etype[7:0]};
        end else if (r_pos == POS_ETYPE_LO) begin
            n_etype = {r_etype[15:8], b};
        end else if (r_pos == POS_IHL) begin
            n_ihl = b[3:0];
        end else if (r_pos == POS_PROTO) begin
            n_proto = b;
        end else if (r_pos >= POS_SRC_FIRST && r_pos <= POS_SRC_LAST) begin
            n_src_ip = {r_src_ip[23:0], b};
        end else if (r_pos >= POS_DST_FIRST && r_pos <= POS_DST_LAST) begin
            n_dst_ip = {r_dst_ip[23:0], b};
        end

        if (r_pos == xport_ofs) begin
            n_sport = {b, r_sport[7:0]};
        end else if (r_pos == xport_ofs + 7'd1) begin
            n_sport = {r_sport[15:8], b};
        end else if (r_pos == xport_ofs + 7'd2) begin
            n_dport = {b, r_dport[7:0]};
        end else if (r_pos == xport_ofs + 7'd3) begin
            n_dport = {r_dport[15:8], b};
        end
    end

    // Acceptance check on the fields as they stand after this byte.
    assign xport_ofs_new = ETH_HDR_LEN + {1'b0, n_ihl, 2'b00};
    assign frame_len     = {1'b0, r_pos} + 8'd1;
    assign ok_base       = (n_etype == ETYPE_IPV4) && (n_ihl >= IHL_MIN)
                           && (frame_len >= MIN_FRAME_LEN);
    assign is_tcp        = (n_proto == PROTO_TCP);
    assign is_udp        = (n_proto == PROTO_UDP);

    always_comb begin
        ok = ok_base;
        if (ok_base && is_tcp) begin
            ok = frame_len >= ({1'b0, xport_ofs_new} + TCP_HDR_LEN);
        end else if (ok_base && is_udp) begin
            ok = frame_len >= ({1'b0, xport_ofs_new} + UDP_HDR_LEN);
        end
    end

    // Result word: everything is zero for a rejected or truncated frame.
    always_comb begin
        n_out = '0;
        if (ok) begin
            n_out.parsed   = 1'b1;
            n_out.src_ip   = n_src_ip;
            n_out.dst_ip   = n_dst_ip;
            n_out.protocol = n_proto;
            if (is_tcp || is_udp) begin
                n_out.sport = n_sport;
                n_out.dport = n_dport;
            end
        end
    end

    assign n_pos       = (r_pos == POS_MAX) ? POS_MAX : r_pos + 7'd1;
    assign n_out_valid = (in_fire && i_data.last_byte) || (r_out_valid && !out_fire);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_etype     <= '0;
            r_ihl       <= '0;
            r_proto     <= '0;
            r_src_ip    <= '0;
            r_dst_ip    <= '0;
            r_sport     <= '0;
            r_dport     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (in_fire) begin
                if (i_data.last_byte) begin
                    // End of frame: start the next one from a clean state.
                    r_pos      <= '0;
                    r_etype    <= '0;
                    r_ihl      <= '0;
                    r_proto    <= '0;
                    r_src_ip   <= '0;
                    r_dst_ip   <= '0;
                    r_sport    <= '0;
                    r_dport    <= '0;
                end else begin
                    r_pos      <= n_pos;
                    r_etype    <= n_etype;
                    r_ihl      <= n_ihl;
                    r_proto    <= n_proto;
                    r_src_ip   <= n_src_ip;
                    r_dst_ip   <= n_dst_ip;
                    r_sport    <= n_sport;
                    r_dport    <= n_dport;
                end
            end
        end
    end

    // Result payload needs no reset; it is qualified by r_out_valid.
    always_ff @(posedge i_clk) begin
        if (in_fire && i_data.last_byte) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    // A final byte that is accepted always yields a result the next cycle.
    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && i_data.last_byte |=> o_valid)
        else $error("final byte accepted without a result");

    // After a final byte the byte counter restarts at zero.
    a_pos_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && i_data.last_byte |=> r_pos == '0)
        else $error("byte position not cleared at end of frame");

    // A rejected frame reports all-zero fields.
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.parsed |-> o_data.src_ip == '0 && o_data.dst_ip == '0
            && o_data.protocol == '0 && o_data.sport == '0 && o_data.dport == '0)
        else $error("rejected frame carries nonzero fields");

    // Ports are reported only for TCP or UDP.
    a_ports_l4_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_data.sport != '0 || o_data.dport != '0)
            |-> o_data.protocol == PROTO_TCP || o_data.protocol == PROTO_UDP)
        else $error("ports reported for a non-transport protocol");

endmodule

`default_nettype wire
